// ===== src/bstk_pkg.sv =====
// Shared types and constants for the bounded stack
package bstk_pkg;

    // Storage geometry
    localparam int STACK_DEPTH = 16;
    localparam int DATA_W      = 32;
    localparam int ADDR_W      = $clog2(STACK_DEPTH);
    localparam int LEVEL_W     = $clog2(STACK_DEPTH + 1);

    // Pop-n count field and burst length limit
    localparam int CNT_W       = 5;
    localparam int MAX_RESULTS = 16;
    localparam int CMP_W       = (LEVEL_W > CNT_W) ? LEVEL_W : CNT_W;

    // Input beat layout
    localparam int ACT_W       = 3;
    localparam int IN_W        = 40;
    localparam int STAT_W      = 2;

    typedef enum logic [ACT_W-1:0] {
        ACT_PUSH      = 3'd0,
        ACT_POP       = 3'd1,
        ACT_POP_N     = 3'd2,
        ACT_PEEK_TOP  = 3'd3,
        ACT_PEEK_BOT  = 3'd4,
        ACT_DUMP      = 3'd5
    } act_t;

    typedef enum logic [STAT_W-1:0] {
        STAT_OK       = 2'd0,
        STAT_OVERFLOW = 2'd1,
        STAT_EMPTY    = 2'd2,
        STAT_FEW      = 2'd3
    } status_t;

    typedef enum logic {
        ST_IDLE,
        ST_BURST
    } state_t;

    // Requests from the sequencer to the stack memory
    typedef struct packed {
        logic              wr_en;
        logic [ADDR_W-1:0] waddr;
        logic [DATA_W-1:0] wdata;
        logic              rd_en;
        logic [ADDR_W-1:0] raddr;
    } ram_req_t;

endpackage

// ===== src/bstk_ram.sv =====
// Simple dual-port RAM, one write and one registered read per cycle
module bstk_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Write port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[waddr] <= wdata;
        end
    end

    // Read port; data holds until the next read
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ===== src/bstk_seq.sv =====
// Action decode, fill level, read burst sequencing and output register
module bstk_seq (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic [bstk_pkg::IN_W-1:0]     in_data,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic [bstk_pkg::DATA_W-1:0]   out_value,
    output logic [bstk_pkg::STAT_W-1:0]   out_status,
    output logic                          out_last,
    output bstk_pkg::ram_req_t            ram_req,
    input  logic [bstk_pkg::DATA_W-1:0]   ram_rdata
);

    bstk_pkg::state_t                 state_reg, state_next;
    logic [bstk_pkg::LEVEL_W-1:0]     level_reg, level_next;
    logic [bstk_pkg::CNT_W-1:0]       rem_reg, rem_next;
    logic [bstk_pkg::ADDR_W-1:0]      addr_reg, addr_next;
    logic                             ovalid_reg, ovalid_next;
    logic [bstk_pkg::DATA_W-1:0]      ovalue_reg, ovalue_next;
    bstk_pkg::status_t                ostat_reg, ostat_next;
    logic                             olast_reg, olast_next;

    logic                             in_fire;
    logic                             out_free;
    logic                             start_burst;
    bstk_pkg::act_t                   act;
    logic [bstk_pkg::DATA_W-1:0]      push_value;
    logic [bstk_pkg::CNT_W-1:0]       pop_count;
    logic [bstk_pkg::CMP_W-1:0]       cnt_x;
    logic [bstk_pkg::CMP_W-1:0]       lvl_x;
    logic                             full;
    logic                             empty;
    logic                             under3;

    // Field unpacking
    assign act        = bstk_pkg::act_t'(in_data[bstk_pkg::ACT_W-1:0]);
    assign push_value = in_data[bstk_pkg::ACT_W +: bstk_pkg::DATA_W];
    assign pop_count  = in_data[bstk_pkg::ACT_W + bstk_pkg::DATA_W +: bstk_pkg::CNT_W];

    assign cnt_x  = bstk_pkg::CMP_W'(pop_count);
    assign lvl_x  = bstk_pkg::CMP_W'(level_reg);
    assign full   = (level_reg == bstk_pkg::LEVEL_W'(bstk_pkg::STACK_DEPTH));
    assign empty  = (level_reg == '0);
    assign under3 = (level_reg < bstk_pkg::LEVEL_W'(3));

    assign out_free = !ovalid_reg || out_ready;
    assign in_fire  = in_valid && in_ready;

    // Handshake outputs
    always_comb
    begin
        in_ready   = (state_reg == bstk_pkg::ST_IDLE) && out_free;
        out_valid  = ovalid_reg;
        out_value  = ovalue_reg;
        out_status = ostat_reg;
        out_last   = olast_reg;
    end

    // Next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            bstk_pkg::ST_IDLE:
            begin
                if (start_burst)
                begin
                    state_next = bstk_pkg::ST_BURST;
                end
            end
            bstk_pkg::ST_BURST:
            begin
                if (out_free && (rem_reg == bstk_pkg::CNT_W'(1)))
                begin
                    state_next = bstk_pkg::ST_IDLE;
                end
            end
            default: state_next = bstk_pkg::ST_IDLE;
        endcase
    end

    // Datapath: decode, memory requests, level and result register
    always_comb
    begin
        level_next   = level_reg;
        rem_next     = rem_reg;
        addr_next    = addr_reg;
        ovalid_next  = ovalid_reg && !out_ready;
        ovalue_next  = ovalue_reg;
        ostat_next   = ostat_reg;
        olast_next   = olast_reg;
        start_burst  = 1'b0;
        ram_req      = '0;
        ram_req.wdata = push_value;
        ram_req.waddr = bstk_pkg::ADDR_W'(level_reg);

        if (in_fire)
        begin
            unique case (act)
                bstk_pkg::ACT_PUSH:
                begin
                    ovalid_next = 1'b1;
                    ovalue_next = '0;
                    olast_next  = 1'b1;
                    if (full)
                    begin
                        ostat_next = bstk_pkg::STAT_OVERFLOW;
                    end
                    else
                    begin
                        ostat_next    = bstk_pkg::STAT_OK;
                        ram_req.wr_en = 1'b1;
                        level_next    = level_reg + bstk_pkg::LEVEL_W'(1);
                    end
                end
                bstk_pkg::ACT_POP:
                begin
                    if (empty)
                    begin
                        ovalid_next = 1'b1;
                        ovalue_next = '0;
                        ostat_next  = bstk_pkg::STAT_EMPTY;
                        olast_next  = 1'b1;
                    end
                    else
                    begin
                        ram_req.rd_en = 1'b1;
                        ram_req.raddr = bstk_pkg::ADDR_W'(level_reg - bstk_pkg::LEVEL_W'(1));
                        level_next    = level_reg - bstk_pkg::LEVEL_W'(1);
                        rem_next      = bstk_pkg::CNT_W'(1);
                        start_burst   = 1'b1;
                    end
                end
                bstk_pkg::ACT_POP_N:
                begin
                    if ((cnt_x == '0) || (cnt_x > bstk_pkg::CMP_W'(bstk_pkg::MAX_RESULTS))
                        || (cnt_x > lvl_x))
                    begin
                        ovalid_next = 1'b1;
                        ovalue_next = '0;
                        ostat_next  = bstk_pkg::STAT_FEW;
                        olast_next  = 1'b1;
                    end
                    else
                    begin
                        ram_req.rd_en = 1'b1;
                        ram_req.raddr = bstk_pkg::ADDR_W'(level_reg - bstk_pkg::LEVEL_W'(1));
                        addr_next     = bstk_pkg::ADDR_W'(level_reg - bstk_pkg::LEVEL_W'(2));
                        level_next    = bstk_pkg::LEVEL_W'(lvl_x - cnt_x);
                        rem_next      = pop_count;
                        start_burst   = 1'b1;
                    end
                end
                bstk_pkg::ACT_PEEK_TOP,
                bstk_pkg::ACT_PEEK_BOT:
                begin
                    if (under3)
                    begin
                        ovalid_next = 1'b1;
                        ovalue_next = '0;
                        ostat_next  = bstk_pkg::STAT_FEW;
                        olast_next  = 1'b1;
                    end
                    else
                    begin
                        ram_req.rd_en = 1'b1;
                        ram_req.raddr = (act == bstk_pkg::ACT_PEEK_TOP)
                                      ? bstk_pkg::ADDR_W'(level_reg - bstk_pkg::LEVEL_W'(3))
                                      : bstk_pkg::ADDR_W'(2);
                        rem_next      = bstk_pkg::CNT_W'(1);
                        start_burst   = 1'b1;
                    end
                end
                bstk_pkg::ACT_DUMP:
                begin
                    if (empty)
                    begin
                        ovalid_next = 1'b1;
                        ovalue_next = '0;
                        ostat_next  = bstk_pkg::STAT_EMPTY;
                        olast_next  = 1'b1;
                    end
                    else
                    begin
                        ram_req.rd_en = 1'b1;
                        ram_req.raddr = bstk_pkg::ADDR_W'(level_reg - bstk_pkg::LEVEL_W'(1));
                        addr_next     = bstk_pkg::ADDR_W'(level_reg - bstk_pkg::LEVEL_W'(2));
                        rem_next      = (lvl_x >= bstk_pkg::CMP_W'(bstk_pkg::MAX_RESULTS))
                                      ? bstk_pkg::CNT_W'(bstk_pkg::MAX_RESULTS)
                                      : bstk_pkg::CNT_W'(lvl_x);
                        start_burst   = 1'b1;
                    end
                end
                default:
                begin
                    // unused action codes are dropped
                end
            endcase
        end
        else if ((state_reg == bstk_pkg::ST_BURST) && out_free)
        begin
            // hand over the word last read, fetch the next one below it
            ovalid_next = 1'b1;
            ovalue_next = ram_rdata;
            ostat_next  = bstk_pkg::STAT_OK;
            olast_next  = (rem_reg == bstk_pkg::CNT_W'(1));
            rem_next    = rem_reg - bstk_pkg::CNT_W'(1);
            if (rem_reg != bstk_pkg::CNT_W'(1))
            begin
                ram_req.rd_en = 1'b1;
                ram_req.raddr = addr_reg;
                addr_next     = addr_reg - bstk_pkg::ADDR_W'(1);
            end
        end
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= bstk_pkg::ST_IDLE;
            level_reg  <= '0;
            rem_reg    <= '0;
            ovalid_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            level_reg  <= level_next;
            rem_reg    <= rem_next;
            ovalid_reg <= ovalid_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        addr_reg   <= addr_next;
        ovalue_reg <= ovalue_next;
        ostat_reg  <= ostat_next;
        olast_reg  <= olast_next;
    end

`ifndef NO_ASSERTIONS
    a_level_bound: assert property (@(posedge clk) disable iff (!rst_n)
        level_reg <= bstk_pkg::LEVEL_W'(bstk_pkg::STACK_DEPTH))
        else $error("fill level beyond stack depth");

    a_burst_rem: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == bstk_pkg::ST_BURST) |-> (rem_reg != '0))
        else $error("burst running with nothing left to send");

    a_burst_end: assert property (@(posedge clk) disable iff (!rst_n)
        ((state_reg == bstk_pkg::ST_BURST) && out_free && (rem_reg == bstk_pkg::CNT_W'(1)))
        |=> ((state_reg == bstk_pkg::ST_IDLE) && ovalid_reg && olast_reg))
        else $error("final beat of burst not marked last");

    a_push_level: assert property (@(posedge clk) disable iff (!rst_n)
        (in_fire && (act == bstk_pkg::ACT_PUSH) && !full)
        |=> (level_reg == $past(level_reg) + bstk_pkg::LEVEL_W'(1)))
        else $error("push did not raise fill level");
`endif

endmodule

// ===== src/bounded_stack_with_peek_top.sv =====
// Bounded LIFO stack of signed 32-bit words with peeks and burst reads.
// Input channel s_*: one beat per action (push, pop, pop n, peek third from
// top, peek third from bottom, dump). Output channel m_*: result beats, each
// with the word on m_tdata, the status on m_tuser and m_tlast on the final
// beat of the action. Unused action codes are taken and give no beat.
// Push and error results are registered in the accept cycle and appear in the
// next cycle. Pop, pop n, peeks and dump read the stack memory, whose read
// port is registered: each word passes the memory read register and then the
// output register. While m_tready is high, the single memory read port sets
// the one-word-per-cycle burst rate.
// s_tready is low while a burst is running and while the output register
// holds a beat that is not being taken. When m_tready is low the output beat
// holds and the burst pauses; nothing is lost. Reset empties the stack at
// once; stored words need no clearing since only pushed entries are read.
module bounded_stack_with_peek_top (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [39:0] s_tdata,   // action[2:0], push_value[34:3], pop_count[39:35]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,   // read_value[31:0]
    output logic [1:0]  m_tuser,   // status[1:0]
    output logic        m_tlast
);

    bstk_pkg::ram_req_t                ram_req;
    logic [bstk_pkg::DATA_W-1:0]       ram_rdata;

    // Sequencer
    bstk_seq u_seq (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (s_tvalid),
        .in_ready   (s_tready),
        .in_data    (s_tdata),
        .out_valid  (m_tvalid),
        .out_ready  (m_tready),
        .out_value  (m_tdata),
        .out_status (m_tuser),
        .out_last   (m_tlast),
        .ram_req    (ram_req),
        .ram_rdata  (ram_rdata)
    );

    // Stack storage
    bstk_ram #(
        .WIDTH (bstk_pkg::DATA_W),
        .DEPTH (bstk_pkg::STACK_DEPTH)
    ) u_ram (
        .clk   (clk),
        .wr_en (ram_req.wr_en),
        .waddr (ram_req.waddr),
        .wdata (ram_req.wdata),
        .rd_en (ram_req.rd_en),
        .raddr (ram_req.raddr),
        .rdata (ram_rdata)
    );

endmodule

// ===== dv/tb_bounded_stack_with_peek_top.sv =====
module tb_bounded_stack_with_peek_top;
    timeunit 1ns;
    timeprecision 1ps;

    // Action codes the block does not define; it swallows them without a beat
    localparam logic [bstk_pkg::ACT_W-1:0] ACT_SPARE6 = 3'd6;
    localparam logic [bstk_pkg::ACT_W-1:0] ACT_SPARE7 = 3'd7;

    localparam int RANDOM_ACTIONS = 430;
    localparam int CYCLE_LIMIT    = 200000;
    localparam int HOLD_CYCLES    = 300;
    localparam int HOLD_AT        = 120;
    localparam int CALM_FROM      = 200;
    localparam int CALM_TO        = 300;
    localparam int IDLE_PCT       = 21;

    typedef struct {
        logic [bstk_pkg::ACT_W-1:0]  act;
        logic [bstk_pkg::DATA_W-1:0] word;
        logic [bstk_pkg::CNT_W-1:0]  count;
        bit                          drain;   // hold this beat back until all results are in
    } action_t;

    typedef struct {
        logic [bstk_pkg::DATA_W-1:0] word;
        bstk_pkg::status_t           status;
        logic                        last;
    } result_t;

    logic                         clk = 1'b0;
    logic                         rst_n = 1'b0;
    logic                         s_tvalid = 1'b0;
    logic                         s_tready;
    logic [bstk_pkg::IN_W-1:0]    s_tdata = '0;   // action[2:0], push_value[34:3], pop_count[39:35]
    logic                         m_tvalid;
    logic                         m_tready = 1'b0;
    logic [bstk_pkg::DATA_W-1:0]  m_tdata;        // read_value[31:0]
    logic [bstk_pkg::STAT_W-1:0]  m_tuser;        // status[1:0]
    logic                         m_tlast;

    action_t            action_q[$];
    result_t            result_q[$];
    action_t            cur_action;

    // Shadow stack used for prediction
    logic [bstk_pkg::DATA_W-1:0]  shadow_stk[bstk_pkg::STACK_DEPTH];
    int                 shadow_lvl = 0;

    int                 n_taken = 0;
    int                 n_beats = 0;
    int                 n_errors = 0;
    int                 n_status[4] = '{0, 0, 0, 0};
    int                 hold_left = 0;
    bit                 hold_done = 1'b0;
    int                 cycles = 0;

    // Generation bookkeeping
    int                 gen_lvl = 0;
    int                 gen_count = 0;
    bit                 barrier_due = 1'b0;

    bounded_stack_with_peek_top u_top (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    initial
    begin
        forever #5 clk = ~clk;
    end

    function automatic bit calm_window();
        return (n_taken >= CALM_FROM) && (n_taken < CALM_TO);
    endfunction

    function automatic bit idle_now();
        return !calm_window() && ($urandom_range(0, 99) < IDLE_PCT);
    endfunction

    task automatic add_result(logic [bstk_pkg::DATA_W-1:0] word, bstk_pkg::status_t status,
                              logic last);
        result_t r;
        r.word   = word;
        r.status = status;
        r.last   = last;
        result_q.push_back(r);
    endtask

    // Work out the result beats of one accepted action and update the shadow stack
    task automatic predict_stack(action_t a);
        int n;
        case (a.act)
            bstk_pkg::ACT_PUSH:
            begin
                if (shadow_lvl >= bstk_pkg::STACK_DEPTH)
                    add_result('0, bstk_pkg::STAT_OVERFLOW, 1'b1);
                else
                begin
                    shadow_stk[shadow_lvl] = a.word;
                    shadow_lvl++;
                    add_result('0, bstk_pkg::STAT_OK, 1'b1);
                end
            end
            bstk_pkg::ACT_POP:
            begin
                if (shadow_lvl == 0)
                    add_result('0, bstk_pkg::STAT_EMPTY, 1'b1);
                else
                begin
                    shadow_lvl--;
                    add_result(shadow_stk[shadow_lvl], bstk_pkg::STAT_OK, 1'b1);
                end
            end
            bstk_pkg::ACT_POP_N:
            begin
                if (a.count == 0 || a.count > bstk_pkg::MAX_RESULTS || a.count > shadow_lvl)
                    add_result('0, bstk_pkg::STAT_FEW, 1'b1);
                else
                    for (int i = 0; i < a.count; i++)
                    begin
                        shadow_lvl--;
                        add_result(shadow_stk[shadow_lvl], bstk_pkg::STAT_OK, i == a.count - 1);
                    end
            end
            bstk_pkg::ACT_PEEK_TOP:
            begin
                if (shadow_lvl < 3)
                    add_result('0, bstk_pkg::STAT_FEW, 1'b1);
                else
                    add_result(shadow_stk[shadow_lvl - 3], bstk_pkg::STAT_OK, 1'b1);
            end
            bstk_pkg::ACT_PEEK_BOT:
            begin
                if (shadow_lvl < 3)
                    add_result('0, bstk_pkg::STAT_FEW, 1'b1);
                else
                    add_result(shadow_stk[2], bstk_pkg::STAT_OK, 1'b1);
            end
            bstk_pkg::ACT_DUMP:
            begin
                if (shadow_lvl == 0)
                    add_result('0, bstk_pkg::STAT_EMPTY, 1'b1);
                else
                begin
                    n = (shadow_lvl < bstk_pkg::MAX_RESULTS) ? shadow_lvl : bstk_pkg::MAX_RESULTS;
                    for (int i = 0; i < n; i++)
                        add_result(shadow_stk[shadow_lvl - 1 - i], bstk_pkg::STAT_OK,
                                   i == n - 1);
                end
            end
            default:
            begin
                // spare codes: no beat, no change
            end
        endcase
    endtask

    // Words biased towards the corners of the signed range
    function automatic logic [bstk_pkg::DATA_W-1:0] pick_word();
        case ($urandom_range(0, 9))
            0:       return 32'h8000_0000;
            1:       return 32'h7fff_ffff;
            2:       return 32'h0000_0000;
            3:       return 32'hffff_ffff;
            default: return $urandom;
        endcase
    endfunction

    // Queue one action and keep a rough count of the fill level for shaping
    task automatic queue_action(logic [bstk_pkg::ACT_W-1:0] act,
                                logic [bstk_pkg::DATA_W-1:0] word,
                                logic [bstk_pkg::CNT_W-1:0] count);
        action_t a;
        a.act   = act;
        a.word  = word;
        a.count = count;
        a.drain = barrier_due;
        barrier_due = 1'b0;
        action_q.push_back(a);
        if (act <= bstk_pkg::ACT_DUMP)
            gen_count++;
        case (act)
            bstk_pkg::ACT_PUSH:  if (gen_lvl < bstk_pkg::STACK_DEPTH) gen_lvl++;
            bstk_pkg::ACT_POP:   if (gen_lvl > 0) gen_lvl--;
            bstk_pkg::ACT_POP_N: if (count != 0 && count <= bstk_pkg::MAX_RESULTS
                                     && count <= gen_lvl)
                                     gen_lvl -= count;
            default:   ;
        endcase
    endtask

    // Driver: offers queued actions, predicts on every accepted beat
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s_tvalid <= 1'b0;
            s_tdata  <= '0;
        end
        else
        begin
            if (s_tvalid && s_tready)
            begin
                predict_stack(cur_action);
                n_taken <= n_taken + 1;
            end
            if (!s_tvalid || s_tready)
            begin
                if (action_q.size() > 0 && !idle_now()
                    && (!action_q[0].drain || result_q.size() == 0))
                begin
                    s_tvalid   <= 1'b1;
                    s_tdata    <= {action_q[0].count, action_q[0].word, action_q[0].act};
                    cur_action <= action_q.pop_front();
                end
                else
                    s_tvalid <= 1'b0;
            end
        end
    end

    // Long receiver hold-off once, so the block backs up onto its input
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hold_left <= 0;
            hold_done <= 1'b0;
        end
        else if (!hold_done && n_taken >= HOLD_AT)
        begin
            hold_left <= HOLD_CYCLES;
            hold_done <= 1'b1;
        end
        else if (hold_left > 0)
            hold_left <= hold_left - 1;
    end

    // Monitor: checks each result beat against the oldest prediction
    always @(posedge clk or negedge rst_n)
    begin : mon_blk
        result_t w;
        if (!rst_n)
            m_tready <= 1'b0;
        else
        begin
            if (m_tvalid && m_tready)
            begin
                if (result_q.size() == 0)
                begin
                    $error("unexpected result beat: read_value %0h status %0d last %0b",
                           m_tdata, m_tuser, m_tlast);
                    n_errors++;
                end
                else
                begin
                    w = result_q.pop_front();
                    n_beats++;
                    n_status[m_tuser]++;
                    if (m_tdata !== w.word)
                    begin
                        $error("read_value: expected %0h, got %0h", w.word, m_tdata);
                        n_errors++;
                    end
                    if (m_tuser !== w.status)
                    begin
                        $error("status: expected %0d, got %0d", w.status, m_tuser);
                        n_errors++;
                    end
                    if (m_tlast !== w.last)
                    begin
                        $error("last: expected %0b, got %0b", w.last, m_tlast);
                        n_errors++;
                    end
                end
            end
            m_tready <= (hold_left == 0) && !idle_now();
        end
    end

    // Timeout
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles == CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles, %0d results outstanding",
                     cycles, result_q.size());
            $display("bounded_stack_with_peek_top verification failed");
            $finish;
        end
    end

    initial
    begin : stim_blk
        int sel;
        int k;
        int hi;

        // Directed: empty-stack errors, signed extremes, peeks at two and three
        // words, pop-n of all words, bad counts and the spare codes
        queue_action(bstk_pkg::ACT_POP,      $urandom, 5'd0);
        queue_action(bstk_pkg::ACT_DUMP,     $urandom, 5'd0);
        queue_action(bstk_pkg::ACT_PEEK_TOP, $urandom, 5'd0);
        queue_action(bstk_pkg::ACT_PEEK_BOT, $urandom, 5'd0);
        queue_action(bstk_pkg::ACT_POP_N,    $urandom, 5'd1);
        queue_action(bstk_pkg::ACT_PUSH,     32'h8000_0000, 5'd0);
        queue_action(bstk_pkg::ACT_PUSH,     32'h7fff_ffff, 5'd31);
        queue_action(bstk_pkg::ACT_PEEK_TOP, $urandom, 5'd0);
        queue_action(bstk_pkg::ACT_PEEK_BOT, $urandom, 5'd0);
        queue_action(bstk_pkg::ACT_PUSH,     32'hffff_ffff, 5'd0);
        queue_action(bstk_pkg::ACT_PEEK_TOP, $urandom, 5'd0);
        queue_action(bstk_pkg::ACT_PEEK_BOT, $urandom, 5'd0);
        queue_action(bstk_pkg::ACT_DUMP,     $urandom, 5'd0);
        queue_action(bstk_pkg::ACT_POP_N,    $urandom, 5'd3);
        queue_action(bstk_pkg::ACT_PUSH,     32'h0000_0000, 5'd0);
        queue_action(bstk_pkg::ACT_POP_N,    $urandom, 5'd0);
        queue_action(bstk_pkg::ACT_POP_N,    $urandom, 5'd17);
        queue_action(bstk_pkg::ACT_POP_N,    $urandom, 5'd31);
        queue_action(bstk_pkg::ACT_POP_N,    $urandom, 5'd2);
        queue_action(bstk_pkg::ACT_POP,      $urandom, 5'd0);
        queue_action(ACT_SPARE6,             $urandom, 5'd16);
        queue_action(ACT_SPARE7,             $urandom, 5'd2);
        queue_action(bstk_pkg::ACT_PUSH,     32'h5555_5555, 5'd0);
        queue_action(bstk_pkg::ACT_PUSH,     32'haaaa_aaaa, 5'd0);
        queue_action(bstk_pkg::ACT_POP_N,    $urandom, 5'd2);

        // Random: mostly well-formed runs, some noise
        barrier_due = 1'b1;
        while (gen_count < RANDOM_ACTIONS)
        begin
            if (gen_count % 90 == 0)
                barrier_due = 1'b1;
            sel = $urandom_range(0, 99);
            if (sel < 30)
            begin
                // fill run, often to full and past it
                k = $urandom_range(1, bstk_pkg::STACK_DEPTH + 2);
                for (int i = 0; i < k; i++)
                    queue_action(bstk_pkg::ACT_PUSH, pick_word(),
                                 bstk_pkg::CNT_W'($urandom_range(0, 31)));
            end
            else if (sel < 45)
            begin
                hi = (gen_lvl > 0) ? gen_lvl : 1;
                queue_action(bstk_pkg::ACT_POP_N, $urandom,
                             bstk_pkg::CNT_W'($urandom_range(1, hi)));
            end
            else if (sel < 55)
                queue_action(bstk_pkg::ACT_DUMP, $urandom,
                             bstk_pkg::CNT_W'($urandom_range(0, 31)));
            else if (sel < 65)
                queue_action($urandom_range(0, 1) ? bstk_pkg::ACT_PEEK_TOP
                                                  : bstk_pkg::ACT_PEEK_BOT,
                             $urandom, bstk_pkg::CNT_W'($urandom_range(0, 31)));
            else if (sel < 75)
            begin
                k = $urandom_range(1, 4);
                for (int i = 0; i < k; i++)
                    queue_action(bstk_pkg::ACT_POP, $urandom,
                                 bstk_pkg::CNT_W'($urandom_range(0, 31)));
            end
            else if (sel < 85)
                // pop-n of exactly all words, or one more than stored
                queue_action(bstk_pkg::ACT_POP_N, $urandom,
                             bstk_pkg::CNT_W'(gen_lvl + $urandom_range(0, 1)));
            else
                queue_action(bstk_pkg::ACT_W'($urandom_range(0, 7)), $urandom,
                             bstk_pkg::CNT_W'($urandom_range(0, 31)));
        end

        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Wait for the stimulus to drain, then for every prediction to be met
        while (action_q.size() > 0 || s_tvalid)
            @(posedge clk);
        while (result_q.size() > 0)
            @(posedge clk);
        repeat (10) @(posedge clk);

        $display("%0d actions accepted, %0d result beats checked", n_taken, n_beats);
        $display("beats by status: ok %0d, overflow %0d, empty %0d, too few %0d",
                 n_status[0], n_status[1], n_status[2], n_status[3]);
        if (n_errors == 0 && result_q.size() == 0)
            $display("bounded_stack_with_peek_top verification clean");
        else
            $display("bounded_stack_with_peek_top verification failed");
        $finish;
    end

endmodule
